/* design/secded_pkg.sv */
package secded_pkg;

    localparam int DATA_BYTES_DEF = 8;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_CHECK  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FIXED = 2'd1,
        ST_FAIL  = 2'd2
    } t_status;

    typedef struct packed {
        t_req        req;
        logic [63:0] data;
        logic [7:0]  parity;
    } t_req_word;

    typedef struct packed {
        t_req        req;
        logic [63:0] data;
        logic [7:0]  stored;
        logic [6:0]  hbits;
        logic        dpar;
    } t_enc_word;

    typedef struct packed {
        logic [63:0] data;
        logic [7:0]  parity;
        t_status     status;
        logic [3:0]  err_byte;
        logic        flip;
        logic [5:0]  flip_bit;
    } t_fix_word;

    typedef struct packed {
        logic [63:0] data;
        logic [7:0]  parity;
        t_status     status;
        logic [3:0]  err_byte;
    } t_rsp_word;

    // code position of data bit k (MSB first), powers of two skipped
    function automatic logic [6:0] code_pos(input logic [6:0] k);
        logic [6:0] p;
        p = k + 7'd3;
        if (p >= 7'd4)  p = p + 7'd1;
        if (p >= 7'd8)  p = p + 7'd1;
        if (p >= 7'd16) p = p + 7'd1;
        if (p >= 7'd32) p = p + 7'd1;
        if (p >= 7'd64) p = p + 7'd1;
        return p;
    endfunction

    // inverse of code_pos for a non power of two position >= 3
    function automatic logic [6:0] pos_index(input logic [6:0] syn);
        logic [2:0] c;
        logic [6:0] k;
        c = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (syn >= (7'd1 << i)) c = c + 3'd1;
        end
        k = syn - 7'd1 - {4'd0, c};
        return k;
    endfunction

endpackage

/* design/secded_enc.sv */
module secded_enc
    import secded_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_req_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_enc_word o_word
);

    localparam logic [63:0] DATA_MASK = {64{1'b1}} << (64 - 8 * DATA_BYTES);

    logic      r_valid;
    t_enc_word r_word;
    t_enc_word n_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word.req    = i_word.req;
        n_word.data   = i_word.data & DATA_MASK;
        n_word.stored = i_word.parity;
        n_word.dpar   = ^n_word.data;
        n_word.hbits  = 7'h7F;
        for (int k = 0; k < 64; k++) begin
            if (n_word.data[63 - k]) n_word.hbits = n_word.hbits ^ code_pos(7'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

/* design/secded_syn.sv */
module secded_syn
    import secded_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_enc_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_fix_word o_word
);

    localparam logic [6:0] DATA_BITS = 7'(8 * DATA_BYTES);
    localparam logic [3:0] ERR_PAR   = 4'(DATA_BYTES);

    logic      r_valid;
    t_fix_word r_word;
    t_fix_word n_word;

    logic       test7;
    logic       new7;
    logic [6:0] syn;
    logic [6:0] k;
    logic       syn_pow2;
    logic       k_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        test7    = ~i_word.dpar ^ (^i_word.hbits);
        syn      = i_word.hbits ^ i_word.stored[6:0];
        syn_pow2 = (syn & (syn - 7'd1)) == 7'd0;
        k        = pos_index(syn);
        k_valid  = k < DATA_BITS;
        // overall bit after flipping the data bit at position syn
        new7     = test7 ^ ~(^syn);

        n_word.data     = i_word.data;
        n_word.parity   = i_word.stored;
        n_word.status   = ST_OK;
        n_word.err_byte = 4'd0;
        n_word.flip     = 1'b0;
        n_word.flip_bit = ~k[5:0];

        priority if (i_word.req == REQ_ENCODE) begin
            n_word.parity = {test7, i_word.hbits};
        end else if (syn == 7'd0) begin
            if (test7 != i_word.stored[7]) begin
                n_word.parity[7] = ~i_word.stored[7];
                n_word.status    = ST_FIXED;
                n_word.err_byte  = ERR_PAR;
            end
        end else if (syn_pow2) begin
            n_word.parity[6:0] = i_word.stored[6:0] ^ syn;
            if (test7 != i_word.stored[7]) begin
                n_word.status = ST_FAIL;
            end else begin
                n_word.status   = ST_FIXED;
                n_word.err_byte = ERR_PAR;
            end
        end else if (k_valid) begin
            n_word.flip = 1'b1;
            if (new7 != i_word.stored[7]) begin
                n_word.status = ST_FAIL;
            end else begin
                n_word.status   = ST_FIXED;
                n_word.err_byte = {1'b0, k[5:3]};
            end
        end else begin
            n_word.status = ST_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

/* design/secded_fix.sv */
module secded_fix
    import secded_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_fix_word i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_rsp_word o_word
);

    logic      r_valid;
    t_rsp_word r_word;
    t_rsp_word n_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word.data     = i_word.data ^ ({63'd0, i_word.flip} << i_word.flip_bit);
        n_word.parity   = i_word.parity;
        n_word.status   = i_word.status;
        n_word.err_byte = i_word.err_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

/* design/secded_72_64_codec_top.sv */
// SECDED (72,64) encoder / checker, one word per cycle.
// Slave stream: tdata carries the data word and the stored parity byte,
// tuser selects encode (0) or check and correct (1).
// Master stream: tdata carries the data word (corrected on check), the
// parity byte (computed on encode, corrected on check), a status code
// (no error, single error fixed, double or uncorrectable) and the index
// of the fixed byte (DATA_BYTES for the parity byte).
// Parity generation, syndrome decode and bit correction each own a register
// stage between an accepted word and o_m_tvalid.
// Throughput is one word per cycle; every stage is a register with its own
// valid bit and loads whenever it is empty or its contents move on.
// When the receiver holds i_m_tready low the pipeline fills and then
// o_s_tready drops; no word is dropped or repeated.
// Reset clears the valid bits only; the pipeline comes out empty.
// DATA_BYTES sets how many high bytes of the data word are covered; lower
// bytes are returned as zero.
module secded_72_64_codec_top
    import secded_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // data_in[63:0], parity_in[71:64]
    input  logic [0:0]  i_s_tuser,   // req_type[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // data_out[63:0], parity_out[71:64],
                                     // status[73:72], err_byte[77:74], zero
);

    t_req_word in_word;
    t_enc_word enc_word;
    t_fix_word fix_word;
    t_rsp_word rsp_word;

    logic enc_valid;
    logic enc_ready;
    logic fix_valid;
    logic fix_ready;

    assign in_word.req    = t_req'(i_s_tuser[0]);
    assign in_word.data   = i_s_tdata[63:0];
    assign in_word.parity = i_s_tdata[71:64];

    secded_enc #(
        .DATA_BYTES(DATA_BYTES)
    ) u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_word  (in_word),
        .o_valid (enc_valid),
        .i_ready (enc_ready),
        .o_word  (enc_word)
    );

    secded_syn #(
        .DATA_BYTES(DATA_BYTES)
    ) u_syn (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (enc_valid),
        .o_ready (enc_ready),
        .i_word  (enc_word),
        .o_valid (fix_valid),
        .i_ready (fix_ready),
        .o_word  (fix_word)
    );

    secded_fix u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fix_valid),
        .o_ready (fix_ready),
        .i_word  (fix_word),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_word  (rsp_word)
    );

    assign o_m_tdata = {2'b00, rsp_word.err_byte, rsp_word.status,
                        rsp_word.parity, rsp_word.data};

endmodule

/* bench/secded_bench_pkg.sv */
`timescale 1ns / 100ps

package secded_bench_pkg;

    import secded_pkg::*;

    localparam int N_DATA_BITS = 8 * DATA_BYTES_DEF;

    // seven Hamming bits in [6:0], overall parity in [7], seed 0xFF
    function automatic logic [7:0] hamming_parity(input logic [63:0] d);
        logic [7:0] p;
        logic [6:0] pos;
        p   = 8'hFF;
        pos = 7'd3;
        for (int k = 0; k < N_DATA_BITS; k++) begin
            if (d[63 - k]) begin
                p[6:0] = p[6:0] ^ pos;
                p[7]   = ~p[7];
            end
            pos = pos + 7'd1;
            if ((pos & (pos - 7'd1)) == 7'd0) pos = pos + 7'd1;
        end
        p[7] = p[7] ^ (^p[6:0]);
        return p;
    endfunction

    // MSB-first data bit index held at code position syn, -1 if none
    function automatic int data_bit_at(input logic [6:0] syn);
        logic [6:0] pos;
        pos = 7'd3;
        for (int k = 0; k < N_DATA_BITS; k++) begin
            if (pos == syn) return k;
            pos = pos + 7'd1;
            if ((pos & (pos - 7'd1)) == 7'd0) pos = pos + 7'd1;
        end
        return -1;
    endfunction

endpackage

/* bench/secded_checker.sv */
`timescale 1ns / 100ps

module secded_checker
    import secded_pkg::*;
    import secded_bench_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // data_in[63:0], parity_in[71:64]
    input  logic [0:0]  i_s_tuser,   // req_type[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // data_out[63:0], parity_out[71:64],
                                     // status[73:72], err_byte[77:74], zero
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] DATA_MASK = ~64'd0 << (64 - N_DATA_BITS);

    t_rsp_word expected_words[$];
    t_rsp_word want;
    int        fails = 0;

    function automatic t_rsp_word corrected_word(input t_req req, input logic [63:0] d_in,
                                                 input logic [7:0] par_in);
        t_rsp_word  r;
        logic [63:0] d;
        logic [7:0]  fresh;
        logic [7:0]  kept;
        logic [6:0]  syn;
        int          k;
        d          = d_in & DATA_MASK;
        fresh      = hamming_parity(d);
        kept       = par_in;
        r.data     = d;
        r.parity   = fresh;
        r.status   = ST_OK;
        r.err_byte = 4'd0;
        if (req == REQ_ENCODE) return r;
        syn = fresh[6:0] ^ kept[6:0];
        if (syn != 7'd0) begin
            if ((syn & (syn - 7'd1)) == 7'd0) begin
                kept[6:0]  = kept[6:0] ^ syn;
                r.err_byte = 4'(DATA_BYTES_DEF);
                r.status   = ST_FIXED;
            end else begin
                k = data_bit_at(syn);
                if (k < 0) begin
                    r.status = ST_FAIL;
                end else begin
                    d[63 - k]  = ~d[63 - k];
                    r.err_byte = 4'(k >> 3);
                    r.status   = ST_FIXED;
                end
            end
            if (r.status == ST_FIXED) begin
                fresh = hamming_parity(d);
                if (fresh[7] != kept[7]) begin
                    r.status   = ST_FAIL;
                    r.err_byte = 4'd0;
                end
            end
        end else if (fresh[7] != kept[7]) begin
            kept[7]    = ~kept[7];
            r.status   = ST_FIXED;
            r.err_byte = 4'(DATA_BYTES_DEF);
        end
        r.data   = d;
        r.parity = kept;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_tdata[63:0] !== want.data) begin
                        $display("%0t: data expected %h, actual %h",
                                 $time, want.data, i_m_tdata[63:0]);
                        fails++;
                    end
                    if (i_m_tdata[71:64] !== want.parity) begin
                        $display("%0t: parity expected %h, actual %h",
                                 $time, want.parity, i_m_tdata[71:64]);
                        fails++;
                    end
                    if (i_m_tdata[73:72] !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, i_m_tdata[73:72]);
                        fails++;
                    end
                    if (i_m_tdata[77:74] !== want.err_byte) begin
                        $display("%0t: err_byte expected %0d, actual %0d",
                                 $time, want.err_byte, i_m_tdata[77:74]);
                        fails++;
                    end
                    if (i_m_tdata[79:78] !== 2'b00) begin
                        $display("%0t: pad expected 0, actual %b",
                                 $time, i_m_tdata[79:78]);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_words.push_back(corrected_word(t_req'(i_s_tuser[0]),
                                                        i_s_tdata[63:0],
                                                        i_s_tdata[71:64]));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

/* bench/tb_secded_72_64_codec_top.sv */
`timescale 1ns / 100ps

module tb_secded_72_64_codec_top;

    import secded_pkg::*;
    import secded_bench_pkg::*;

    localparam int N_RANDOM = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;   // data_in[63:0], parity_in[71:64]
    logic [0:0]  i_s_tuser;   // req_type[0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;   // data_out[63:0], parity_out[71:64],
                              // status[73:72], err_byte[77:74], zero
    int          fail_count;
    int          pending;
    int          rx_cycle;
    logic        steady;

    secded_72_64_codec_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    secded_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_word(input t_req req, input logic [63:0] d, input logic [7:0] p);
        if (!steady && $urandom_range(0, 99) < 14) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {p, d};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // codeword of d with the bits in flips inverted (parity in [71:64])
    task automatic send_damaged(input logic [63:0] d, input logic [71:0] flips);
        send_word(REQ_CHECK, d ^ flips[63:0], hamming_parity(d) ^ flips[71:64]);
    endtask

    function automatic logic [63:0] rand_data();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return ~64'd0;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random stalls, one long hold-off, one stretch without stalls
    initial begin
        i_m_tready = 1'b0;
        rx_cycle   = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            rx_cycle++;
            if (rx_cycle >= 600 && rx_cycle < 800)
                i_m_tready <= 1'b0;
            else if (rx_cycle >= 1600 && rx_cycle < 2200)
                i_m_tready <= 1'b1;
            else
                i_m_tready <= ($urandom_range(0, 99) >= 14);
            @(posedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [63:0] d;
        logic [71:0] flips;
        int          a;
        int          b;
        int          sel;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_ENCODE;
        steady     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_word(REQ_ENCODE, 64'd0, 8'h00);
        send_word(REQ_ENCODE, ~64'd0, 8'hFF);
        send_word(REQ_ENCODE, 64'h8000_0000_0000_0000, 8'h5A);
        send_word(REQ_ENCODE, 64'h0000_0000_0000_0001, 8'hA5);
        send_damaged(64'd0, 72'd0);
        send_damaged(~64'd0, 72'd0);
        d = {$urandom, $urandom};
        send_damaged(d, 72'd1 << 63);
        send_damaged(d, 72'd1 << 0);
        send_damaged(d, 72'd1 << 35);
        send_damaged(d, 72'd1 << 71);
        send_damaged(d, 72'd1 << 64);
        send_damaged(d, 72'd1 << 70);
        send_damaged(d, (72'd1 << 63) | (72'd1 << 2));
        send_damaged(d, (72'd1 << 40) | (72'd1 << 71));
        send_damaged(d, (72'd1 << 64) | (72'd1 << 65));
        send_damaged(d, {8'h7F, 64'd0});
        send_damaged(d, {8'h48, 64'd0});
        send_damaged(~64'd0, {8'h50, 64'd0});
        send_word(REQ_CHECK, d, 8'h00);
        send_word(REQ_CHECK, ~64'd0, 8'h00);
        send_word(REQ_ENCODE, d, 8'hC3);

        // random
        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 1000 && i < 1300);
            d      = rand_data();
            sel    = $urandom_range(0, 99);
            if (sel < 20) begin
                send_word(REQ_ENCODE, d, 8'($urandom));
            end else if (sel < 40) begin
                send_damaged(d, 72'd0);
            end else if (sel < 65) begin
                send_damaged(d, 72'd1 << $urandom_range(0, 63));
            end else if (sel < 75) begin
                send_damaged(d, 72'd1 << $urandom_range(64, 71));
            end else if (sel < 88) begin
                a = $urandom_range(0, 71);
                b = $urandom_range(0, 70);
                if (b >= a) b++;
                flips = (72'd1 << a) | (72'd1 << b);
                send_damaged(d, flips);
            end else begin
                send_word(REQ_CHECK, d, 8'($urandom));
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
